FILE: rtl/i64alu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i64alu_pkg: shared types and constants of the 64-bit integer ALU
// Operand width, opcode codes and the request and response word types.
// ----------------------------------------------------------------------------
package i64alu_pkg;

  localparam int unsigned DATA_WIDTH = 64;  // working width, 8 to 64
  localparam int unsigned CNT_W      = $clog2(DATA_WIDTH);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_POW = 3'd5,
    OP_NEG = 3'd6,
    OP_NOT = 3'd7
  } opcode_e;

  typedef struct packed {
    opcode_e            opcode;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } alu_req_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic               div_by_zero;
  } alu_rsp_t;

endpackage : i64alu_pkg
`default_nettype wire

FILE: rtl/int64_alu_with_power_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int64_alu_with_power_unit: integer ALU with a serial multiply, divide and power
// Add, subtract, multiply, divide, remainder, power, negate and bitwise not
// on signed operands, wrapping in DATA_WIDTH-bit two's complement.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                  | word
//  ----------+----------------------------+-----------------------------
//  request   | start high, busy low       | req_i  (opcode, operand_a/b)
//  response  | valid_o high for one cycle | rsp_o  (result, div_by_zero)
//
// Add, sub, negate, not, zero-divisor and the power corners (exponent zero,
// negative or one) answer in the cycle after start.
// Multiply runs on the one-bit-per-cycle shift-and-add multiplier; divide
// and remainder run on the one-bit-per-cycle restoring divider in the same
// registers. Power walks the exponent from its low bit: every exponent bit
// costs one or two passes of the multiplier.
// Reset clears the sequencer; the receiver cannot stall, so a result shows
// for exactly one cycle and the next request is taken that same cycle.
// ----------------------------------------------------------------------------
module int64_alu_with_power_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  input  wire i64alu_pkg::alu_req_t req_i,
  output logic                      busy,
  output logic                      valid_o,
  output i64alu_pkg::alu_rsp_t      rsp_o
);
  import i64alu_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_POW} state_e;
  typedef enum logic [1:0] {R_OP, R_ACC, R_SQ} ret_e;

  state_e          state_q;
  ret_e            ret_q;
  opcode_e         op_q;
  logic [CNT_W-1:0] cnt_q;
  // shared serial datapath: multiplicand / dividend, multiplier / divisor,
  // product / partial remainder
  logic [W-1:0]    mx_q, my_q, mp_q;
  logic [W-1:0]    a_q, b_q;
  logic [W-1:0]    acc_q, base_q, ex_q;
  logic            neg_q;

  logic [W-1:0]    a_in, b_in, abs_a, abs_b;
  logic [W-1:0]    mul_p_nx;
  logic [W:0]      div_t;
  logic            div_ok;
  logic [W-1:0]    div_rem_nx, div_quo_nx, div_res, mod_neg, mod_res;
  logic            last;

  function automatic logic signed [63:0] sext(input logic [W-1:0] v);
    return 64'(signed'(v));
  endfunction

  assign a_in  = req_i.operand_a[W-1:0];
  assign b_in  = req_i.operand_b[W-1:0];
  assign abs_a = a_in[W-1] ? (W'(0) - a_in) : a_in;
  assign abs_b = b_in[W-1] ? (W'(0) - b_in) : b_in;
  assign last  = (cnt_q == CNT_W'(W - 1));
  assign busy  = (state_q != S_IDLE);

  always_comb begin
    // one shift-and-add step, low word only
    mul_p_nx   = mp_q + (my_q[0] ? mx_q : W'(0));
    // one restoring divide step
    div_t      = {mp_q, mx_q[W-1]} - {1'b0, my_q};
    div_ok     = ~div_t[W];
    div_rem_nx = div_ok ? div_t[W-1:0] : {mp_q[W-2:0], mx_q[W-1]};
    div_quo_nx = {mx_q[W-2:0], div_ok};
    div_res    = (a_q[W-1] != b_q[W-1]) ? (W'(0) - div_quo_nx) : div_quo_nx;
    mod_neg    = a_q[W-1] ? (W'(0) - div_rem_nx) : div_rem_nx;
    mod_res    = mod_neg[W-1] ? (mod_neg + b_q) : mod_neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_o <= 1'b0;
      ret_q   <= R_OP;
      cnt_q   <= '0;
    end else begin
      valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q  <= req_i.opcode;
            a_q   <= a_in;
            b_q   <= b_in;
            cnt_q <= '0;
            mp_q  <= '0;
            rsp_o.div_by_zero <= 1'b0;
            unique case (req_i.opcode) inside
              OP_ADD: begin
                rsp_o.result <= sext(a_in + b_in);
                valid_o      <= 1'b1;
              end
              OP_SUB: begin
                rsp_o.result <= sext(a_in - b_in);
                valid_o      <= 1'b1;
              end
              OP_NEG: begin
                rsp_o.result <= sext(W'(0) - a_in);
                valid_o      <= 1'b1;
              end
              OP_NOT: begin
                rsp_o.result <= sext(~a_in);
                valid_o      <= 1'b1;
              end
              OP_MUL: begin
                mx_q    <= a_in;
                my_q    <= b_in;
                ret_q   <= R_OP;
                state_q <= S_MUL;
              end
              OP_DIV, OP_MOD: begin
                if (b_in == W'(0)) begin
                  rsp_o.result      <= '0;
                  rsp_o.div_by_zero <= 1'b1;
                  valid_o           <= 1'b1;
                end else begin
                  mx_q    <= abs_a;
                  my_q    <= abs_b;
                  state_q <= S_DIV;
                end
              end
              default: begin  // power
                if (b_in == W'(0)) begin
                  rsp_o.result <= 64'sd1;
                  valid_o      <= 1'b1;
                end else if (b_in[W-1]) begin
                  rsp_o.result <= '0;
                  valid_o      <= 1'b1;
                end else if (b_in == W'(1)) begin
                  rsp_o.result <= sext(a_in);
                  valid_o      <= 1'b1;
                end else begin
                  base_q  <= abs_a;
                  acc_q   <= W'(1);
                  ex_q    <= b_in;
                  neg_q   <= a_in[W-1] & b_in[0];
                  state_q <= S_POW;
                end
              end
            endcase
          end
        end
        S_MUL: begin
          mp_q  <= mul_p_nx;
          mx_q  <= {mx_q[W-2:0], 1'b0};
          my_q  <= {1'b0, my_q[W-1:1]};
          cnt_q <= cnt_q + 1'b1;
          if (last) begin
            cnt_q <= '0;
            unique case (ret_q)
              R_OP: begin
                rsp_o.result <= sext(mul_p_nx);
                valid_o      <= 1'b1;
                state_q      <= S_IDLE;
              end
              R_ACC: begin
                // accumulate done, now square the base
                acc_q <= mul_p_nx;
                mx_q  <= base_q;
                my_q  <= base_q;
                mp_q  <= '0;
                ret_q <= R_SQ;
              end
              default: begin
                base_q  <= mul_p_nx;
                ex_q    <= {1'b0, ex_q[W-1:1]};
                state_q <= S_POW;
              end
            endcase
          end
        end
        S_DIV: begin
          mp_q  <= div_rem_nx;
          mx_q  <= div_quo_nx;
          cnt_q <= cnt_q + 1'b1;
          if (last) begin
            cnt_q        <= '0;
            rsp_o.result <= sext((op_q == OP_DIV) ? div_res : mod_res);
            valid_o      <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: begin  // power step: finish, or pick the next multiply
          mp_q  <= '0;
          cnt_q <= '0;
          if (ex_q == W'(0)) begin
            rsp_o.result <= sext(neg_q ? (W'(0) - acc_q) : acc_q);
            valid_o      <= 1'b1;
            state_q      <= S_IDLE;
          end else if (ex_q[0]) begin
            mx_q    <= acc_q;
            my_q    <= base_q;
            ret_q   <= R_ACC;
            state_q <= S_MUL;
          end else begin
            mx_q    <= base_q;
            my_q    <= base_q;
            ret_q   <= R_SQ;
            state_q <= S_MUL;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result only comes out while the sequencer is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> !busy)
    else $error("result strobe while busy");
  // a zero-divisor flag always comes with a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.div_by_zero) |-> (rsp_o.result == 64'sd0))
    else $error("div_by_zero with nonzero result");
  // work begins only on an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy without start");
`endif

endmodule : int64_alu_with_power_unit
`default_nettype wire
